>>> src/kfkd_pkg.sv
// Package for the keyboard frame keymap decoder.
// Holds link byte codes, the frame phase type and the three-layer keymap ROM.
// No dependencies.
`default_nettype none

package kfkd_pkg;

    localparam logic [7:0] BYTE_XBOF    = 8'hFF;
    localparam logic [7:0] BYTE_BOF     = 8'hC0;
    localparam logic [7:0] BYTE_EOF     = 8'hC1;
    localparam logic [8:0] BLUE_LAYER_KEY  = 9'd126;
    localparam logic [8:0] GREEN_LAYER_KEY = 9'd125;

    typedef enum logic [1:0] {
        PH_OUTSIDE  = 2'd0,
        PH_BEGIN    = 2'd1,
        PH_SCANCODE = 2'd2,
        PH_CHECK    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [8:0] normal;
        logic [8:0] blue;
        logic [8:0] green;
    } keymap_row_t;

    function automatic keymap_row_t keymap_row(input logic [6:0] num);
        keymap_row_t r;
        r = '{normal: 9'd0, blue: 9'd0, green: 9'd0};
        unique case (num)
            7'd3:  r = '{9'd44,  9'd352, 9'd0};
            7'd9:  r = '{9'd16,  9'd2,   9'd59};
            7'd10: r = '{9'd17,  9'd3,   9'd60};
            7'd11: r = '{9'd18,  9'd4,   9'd61};
            7'd12: r = '{9'd19,  9'd5,   9'd62};
            7'd13: r = '{9'd20,  9'd6,   9'd63};
            7'd14: r = '{9'd21,  9'd7,   9'd64};
            7'd16: r = '{9'd45,  9'd0,   9'd0};
            7'd17: r = '{9'd30,  9'd0,   9'd0};
            7'd18: r = '{9'd31,  9'd0,   9'd0};
            7'd19: r = '{9'd32,  9'd0,   9'd0};
            7'd20: r = '{9'd33,  9'd0,   9'd0};
            7'd21: r = '{9'd34,  9'd0,   9'd0};
            7'd22: r = '{9'd35,  9'd0,   9'd0};
            7'd23: r = '{9'd57,  9'd0,   9'd0};
            7'd24: r = '{9'd58,  9'd0,   9'd0};
            7'd26: r = '{9'd97,  9'd0,   9'd0};
            7'd27: r = '{9'd15,  9'd0,   9'd0};
            7'd34: r = '{9'd126, 9'd0,   9'd0};
            7'd35: r = '{9'd56,  9'd0,   9'd0};
            7'd36: r = '{9'd125, 9'd0,   9'd0};
            7'd44: r = '{9'd46,  9'd223, 9'd0};
            7'd45: r = '{9'd47,  9'd0,   9'd0};
            7'd46: r = '{9'd48,  9'd0,   9'd0};
            7'd47: r = '{9'd49,  9'd181, 9'd0};
            7'd50: r = '{9'd14,  9'd0,   9'd0};
            7'd55: r = '{9'd57,  9'd0,   9'd0};
            7'd56: r = '{9'd12,  9'd26,  9'd87};
            7'd57: r = '{9'd13,  9'd27,  9'd88};
            7'd58: r = '{9'd53,  9'd43,  9'd0};
            7'd60: r = '{9'd22,  9'd8,   9'd65};
            7'd61: r = '{9'd23,  9'd9,   9'd66};
            7'd62: r = '{9'd24,  9'd10,  9'd67};
            7'd63: r = '{9'd25,  9'd11,  9'd68};
            7'd68: r = '{9'd36,  9'd102, 9'd0};
            7'd69: r = '{9'd37,  9'd139, 9'd0};
            7'd70: r = '{9'd38,  9'd156, 9'd0};
            7'd71: r = '{9'd39,  9'd0,   9'd0};
            7'd72: r = '{9'd103, 9'd0,   9'd104};
            7'd76: r = '{9'd50,  9'd111, 9'd78};
            7'd77: r = '{9'd51,  9'd0,   9'd74};
            7'd78: r = '{9'd52,  9'd231, 9'd0};
            7'd80: r = '{9'd111, 9'd0,   9'd0};
            7'd81: r = '{9'd105, 9'd0,   9'd102};
            7'd82: r = '{9'd108, 9'd0,   9'd109};
            7'd83: r = '{9'd106, 9'd0,   9'd107};
            7'd86: r = '{9'd40,  9'd0,   9'd0};
            7'd87: r = '{9'd28,  9'd0,   9'd0};
            7'd88: r = '{9'd42,  9'd0,   9'd0};
            7'd89: r = '{9'd54,  9'd0,   9'd0};
            default: r = '{normal: 9'd0, blue: 9'd0, green: 9'd0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/keyboard_frame_keymap_decoder.sv
// Keyboard frame keymap decoder: frame tracking, layered keymap lookup, meta layer flags.
// Depends on kfkd_pkg for byte codes, the phase type and the keymap ROM.
//
//   channel | dir | tdata bits (lowest first)              | transfer
//   s_      | in  | [7:0] rx_byte                           | s_tvalid & s_tready
//   m_      | out | [8:0] key_code, [9] pressed, [10] mapped | m_tvalid & m_tready
//
// One byte per cycle while the output is not stalled: a byte is held in the input register,
// and its result (scancode bytes only) lands in the output register when it advances.
// m_tvalid is driven from the output register, never straight from the input transfer.
// aresetn (synchronous) sets the phase to outside and clears both layer flags.
// A stalled output holds the input register; s_tready drops only when both are full.
`default_nettype none

module keyboard_frame_keymap_decoder
    import kfkd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [8:0] key_code, [9] pressed, [10] mapped, zero fill
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    phase_t      phase_reg, phase_next;
    logic        blue_reg, blue_next;
    logic        green_reg, green_next;
    logic        out_valid_reg, out_valid_next;
    logic [8:0]  key_code_reg;
    logic        pressed_reg;
    logic        mapped_reg;

    logic        advance;
    logic        res_valid;
    logic [8:0]  res_key;
    logic        res_down;
    logic [8:0]  layer_key;
    keymap_row_t row;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign row      = keymap_row(in_byte_reg[6:0]);
    assign res_down = !in_byte_reg[7];

    always_comb begin
        if (green_reg) begin
            layer_key = row.green;
        end else if (blue_reg) begin
            layer_key = row.blue;
        end else begin
            layer_key = 9'd0;
        end
        res_key = (layer_key != 9'd0) ? layer_key : row.normal;
    end

    always_comb begin
        phase_next = phase_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        res_valid  = 1'b0;
        if (advance) begin
            if (in_byte_reg == BYTE_EOF) begin
                phase_next = PH_OUTSIDE;
            end else begin
                unique case (phase_reg)
                    PH_OUTSIDE: begin
                        if (in_byte_reg == BYTE_XBOF) begin
                            phase_next = PH_BEGIN;
                        end
                    end
                    PH_BEGIN: begin
                        phase_next = (in_byte_reg == BYTE_BOF) ? PH_SCANCODE : PH_OUTSIDE;
                    end
                    PH_SCANCODE: begin
                        phase_next = PH_CHECK;
                        res_valid  = 1'b1;
                        if (res_key == BLUE_LAYER_KEY) begin
                            blue_next = res_down;
                        end
                        if (res_key == GREEN_LAYER_KEY) begin
                            green_next = res_down;
                        end
                    end
                    PH_CHECK: begin
                        phase_next = PH_CHECK;
                    end
                    default: begin
                        phase_next = PH_OUTSIDE;
                    end
                endcase
            end
        end
    end

    always_comb begin
        if (advance) begin
            out_valid_next = res_valid;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_OUTSIDE;
            blue_reg      <= 1'b0;
            green_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            phase_reg     <= phase_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (res_valid) begin
            key_code_reg <= res_key;
            pressed_reg  <= res_down;
            mapped_reg   <= (res_key != 9'd0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, mapped_reg, pressed_reg, key_code_reg};

endmodule

`default_nettype wire
